@@ design/tcb_pkg.sv @@
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants for the touch calibrate core
// Button codes, register indexes, hit boxes, sequencer states and the
// request/response records of the shared divider.
// ----------------------------------------------------------------------------
package tcb_pkg;

  // Default panel geometry
  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  // Datapath widths (cover screen sizes up to 1024)
  localparam int SMP_W      = 12;             // raw converter sample
  localparam int DIFF_W     = SMP_W + 1;      // signed raw difference
  localparam int POS_W      = 10;             // clamped screen position
  localparam int SCALE_W    = POS_W + 1;      // signed screen extent
  localparam int PROD_W     = DIFF_W + SCALE_W;
  localparam int MAG_W      = PROD_W - 2;     // product magnitude bits
  localparam int QUO_W      = MAG_W + 1;      // signed quotient
  localparam int DIV_STEPS  = MAG_W / 2;      // two quotient bits per cycle
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Button codes
  localparam logic [2:0] BUTTON_NONE   = 3'd0;
  localparam logic [2:0] BUTTON_ARM    = 3'd1;
  localparam logic [2:0] BUTTON_DEPLOY = 3'd2;
  localparam logic [2:0] BUTTON_YES    = 3'd3;
  localparam logic [2:0] BUTTON_NO     = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_CAL_X_LOW   = 3'd0;
  localparam logic [2:0] REG_CAL_X_HIGH  = 3'd1;
  localparam logic [2:0] REG_CAL_Y_LOW   = 3'd2;
  localparam logic [2:0] REG_CAL_Y_HIGH  = 3'd3;
  localparam logic [2:0] REG_ORIENTATION = 3'd4;
  localparam logic [2:0] REG_DEPLOY_OK   = 3'd5;
  localparam logic [2:0] REG_CONFIRM     = 3'd6;
  localparam logic [2:0] REG_COOLDOWN    = 3'd7;

  // Hit boxes: origin and extent in screen pixels
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] w;
    logic [POS_W-1:0] h;
  } tcb_box_t;

  localparam tcb_box_t BOX_ARM    = '{x: 10'd8,   y: 10'd230, w: 10'd108, h: 10'd44};
  localparam tcb_box_t BOX_DEPLOY = '{x: 10'd124, y: 10'd230, w: 10'd108, h: 10'd44};
  localparam tcb_box_t BOX_YES    = '{x: 10'd40,  y: 10'd175, w: 10'd70,  h: 10'd36};
  localparam tcb_box_t BOX_NO     = '{x: 10'd130, y: 10'd175, w: 10'd70,  h: 10'd36};

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_START = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_OUT   = 6'b100000
  } tcb_state_e;

  // Divider request and response
  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } tcb_div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quo;
  } tcb_div_rsp_t;

  // Point inside a half-open box
  function automatic logic in_box(tcb_box_t b, logic [POS_W-1:0] px,
                                  logic [POS_W-1:0] py);
    logic [POS_W:0] x_end;
    logic [POS_W:0] y_end;
    x_end = {1'b0, b.x} + {1'b0, b.w};
    y_end = {1'b0, b.y} + {1'b0, b.h};
    return (px >= b.x) && ({1'b0, px} < x_end) &&
           (py >= b.y) && ({1'b0, py} < y_end);
  endfunction

  // Clamp a signed mapped value to 0..max
  function automatic logic [POS_W-1:0] clamp_axis(logic signed [PROD_W-1:0] v,
                                                  logic [POS_W-1:0] max);
    logic signed [PROD_W-1:0] max_s;
    max_s = $signed({{(PROD_W-POS_W){1'b0}}, max});
    if (v < 0) begin
      return '0;
    end else if (v > max_s) begin
      return max;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

@@ design/tcb_div.sv @@
// ----------------------------------------------------------------------------
// tcb_div: shared iterative signed divider
// Restoring division on magnitudes, two quotient bits per cycle; the
// quotient truncates toward zero. One request at a time.
// ----------------------------------------------------------------------------
module tcb_div import tcb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tcb_div_req_t req_i,
  output tcb_div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  neg_q, neg_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [SMP_W-1:0]      rem_q, rem_d;
  logic [MAG_W-1:0]      quo_q, quo_d;
  logic [SMP_W-1:0]      dmag_q, dmag_d;

  logic [PROD_W-1:0]     num_abs;
  logic [DIFF_W-1:0]     den_abs;
  logic [SMP_W-1:0]      rem_step;
  logic [MAG_W-1:0]      quo_step;

  // Magnitudes of the operands
  assign num_abs = req_i.num[PROD_W-1] ? PROD_W'(-req_i.num) : req_i.num;
  assign den_abs = req_i.den[DIFF_W-1] ? DIFF_W'(-req_i.den) : req_i.den;

  // Two restoring steps
  always_comb begin
    logic [SMP_W-1:0] r;
    logic [MAG_W-1:0] q;
    logic [SMP_W:0]   trial;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < 2; i++) begin
      trial = {r, q[MAG_W-1]};
      q     = {q[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, dmag_q}) begin
        trial = trial - {1'b0, dmag_q};
        q[0]  = 1'b1;
      end
      r = trial[SMP_W-1:0];
    end
    rem_step = r;
    quo_step = q;
  end

  // Load on start, then iterate
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_abs[MAG_W-1:0];
      dmag_d = den_abs[SMP_W-1:0];
      neg_d  = req_i.num[PROD_W-1] ^ req_i.den[DIFF_W-1];
    end else if (busy_q) begin
      rem_d = rem_step;
      quo_d = quo_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
  end

  // Apply the sign
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

@@ design/tcb_hit.sv @@
// ----------------------------------------------------------------------------
// tcb_hit: button hit test
// Tests the Yes and No boxes in confirm mode, otherwise Arm and, when deploy is enabled, Deploy.
// ----------------------------------------------------------------------------
module tcb_hit import tcb_pkg::*; (
  input  logic [POS_W-1:0] px_i,
  input  logic [POS_W-1:0] py_i,
  input  logic             confirm_i,
  input  logic             deploy_ok_i,
  output logic [2:0]       button_o
);

  always_comb begin
    button_o = BUTTON_NONE;
    if (confirm_i) begin
      if (in_box(BOX_YES, px_i, py_i)) begin
        button_o = BUTTON_YES;
      end else if (in_box(BOX_NO, px_i, py_i)) begin
        button_o = BUTTON_NO;
      end
    end else begin
      if (in_box(BOX_ARM, px_i, py_i)) begin
        button_o = BUTTON_ARM;
      end else if (deploy_ok_i && in_box(BOX_DEPLOY, px_i, py_i)) begin
        button_o = BUTTON_DEPLOY;
      end
    end
  end

endmodule

@@ design/touch_calibrate_and_button_hit_core.sv @@
// ----------------------------------------------------------------------------
// touch_calibrate_and_button_hit_core: touch poll calibration and hit test
// Averages four X and four Y samples, maps them to screen coordinates and
// reports button presses under a millisecond cooldown.
// ----------------------------------------------------------------------------
// A pen-down poll runs ST_MUL, ST_START and ST_WAIT once per axis, then ST_FIN
// and ST_OUT, before the core is ready again: one shared multiplier and one
// shared two-bit-per-cycle divider serve both axes. A pen-up poll goes from
// ST_IDLE straight to ST_OUT. The result sits in an output register, so the
// next poll is taken while it waits; a result that is not taken holds the core
// in its final state until the output frees up.
module touch_calibrate_and_button_hit_core import tcb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i,
  // Poll input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pen_down[0], now_ms[32:1], x_sample_a..d[80:33], y_sample_a..d[128:81]
  input  logic [135:0] s_axis_tdata,
  // Result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // button[2:0], touched[3], screen_x[12:4], screen_y[22:13],
  // raw_x[35:23], raw_y[48:36]
  output logic [55:0]  m_axis_tdata
);

  localparam logic [POS_W-1:0] XMax = POS_W'(SCREEN_WIDTH - 1);
  localparam logic [POS_W-1:0] YMax = POS_W'(SCREEN_HEIGHT - 1);

  // Configuration registers
  logic [SMP_W-1:0] cal_x_low_q, cal_x_high_q, cal_y_low_q, cal_y_high_q;
  logic [2:0]       orient_q;
  logic             deploy_ok_q, confirm_q;
  logic [15:0]      cooldown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_x_low_q  <= '0;
      cal_x_high_q <= '1;
      cal_y_low_q  <= '0;
      cal_y_high_q <= '1;
      orient_q     <= '0;
      deploy_ok_q  <= 1'b0;
      confirm_q    <= 1'b0;
      cooldown_q   <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAL_X_LOW:   cal_x_low_q  <= cfg_wdata_i[SMP_W-1:0];
        REG_CAL_X_HIGH:  cal_x_high_q <= cfg_wdata_i[SMP_W-1:0];
        REG_CAL_Y_LOW:   cal_y_low_q  <= cfg_wdata_i[SMP_W-1:0];
        REG_CAL_Y_HIGH:  cal_y_high_q <= cfg_wdata_i[SMP_W-1:0];
        REG_ORIENTATION: orient_q     <= cfg_wdata_i[2:0];
        REG_DEPLOY_OK:   deploy_ok_q  <= cfg_wdata_i[0];
        REG_CONFIRM:     confirm_q    <= cfg_wdata_i[0];
        REG_COOLDOWN:    cooldown_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input unpacking and averaging
  logic              in_pen;
  logic [31:0]       in_now;
  logic [SMP_W+1:0]  x_sum, y_sum;
  logic              in_beat;

  assign in_pen  = s_axis_tdata[0];
  assign in_now  = s_axis_tdata[32:1];
  assign x_sum   = 14'(s_axis_tdata[44:33]) + 14'(s_axis_tdata[56:45]) +
                   14'(s_axis_tdata[68:57]) + 14'(s_axis_tdata[80:69]);
  assign y_sum   = 14'(s_axis_tdata[92:81]) + 14'(s_axis_tdata[104:93]) +
                   14'(s_axis_tdata[116:105]) + 14'(s_axis_tdata[128:117]);
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // Sequencer and datapath registers
  tcb_state_e               state_q, state_d;
  logic                     axis_y_q, axis_y_d;
  logic                     pen_q;
  logic [31:0]              now_q;
  logic [SMP_W-1:0]         rx_q, ry_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DIFF_W-1:0] den_q;
  logic signed [QUO_W-1:0]  qx_q, qy_q;
  logic [POS_W-1:0]         sx_q, sy_q;
  logic                     cool_ok_q;

  // State
  logic [31:0]              last_evt_q;
  logic [8:0]               held_sx_q;
  logic [9:0]               held_sy_q;
  logic [12:0]              held_rx_q, held_ry_q;

  // Output register
  logic                     out_valid_q;
  logic [55:0]              out_data_q;
  logic                     out_load;

  tcb_div_req_t div_req;
  tcb_div_rsp_t div_rsp;
  logic [2:0]   hit_button;

  // Operand selection for the current axis
  logic                     swap;
  logic [SMP_W-1:0]         mv, lo, hi;
  logic signed [DIFF_W-1:0] diff, den;
  logic signed [SCALE_W-1:0] scale;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [QUO_W-1:0]  quo_sel;

  assign swap  = orient_q[0];
  assign mv    = (axis_y_q ^ swap) ? ry_q : rx_q;
  assign lo    = axis_y_q ? cal_y_low_q  : cal_x_low_q;
  assign hi    = axis_y_q ? cal_y_high_q : cal_x_high_q;
  assign diff  = $signed({1'b0, mv}) - $signed({1'b0, lo});
  assign den   = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign scale = $signed({1'b0, axis_y_q ? YMax : XMax});
  assign prod_d = PROD_W'(diff) * PROD_W'(scale);
  assign quo_sel = (den_q == '0) ? '0 : div_rsp.quo;

  // Inversion and clamp
  logic signed [PROD_W-1:0] tx, ty;
  assign tx = orient_q[1] ? ($signed({{(PROD_W-POS_W){1'b0}}, XMax}) - PROD_W'(qx_q))
                          : PROD_W'(qx_q);
  assign ty = orient_q[2] ? ($signed({{(PROD_W-POS_W){1'b0}}, YMax}) - PROD_W'(qy_q))
                          : PROD_W'(qy_q);

  assign div_req.start = (state_q == ST_START);
  assign div_req.num   = prod_q;
  assign div_req.den   = den_q;

  tcb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tcb_hit u_hit (
    .px_i        (sx_q),
    .py_i        (sy_q),
    .confirm_i   (confirm_q),
    .deploy_ok_i (deploy_ok_q),
    .button_o    (hit_button)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Next state
  always_comb begin
    state_d  = state_q;
    axis_y_d = axis_y_q;
    unique case (state_q)
      ST_IDLE: begin
        axis_y_d = 1'b0;
        if (in_beat) begin
          state_d = in_pen ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          axis_y_d = 1'b1;
          state_d  = axis_y_q ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_y_q    <= 1'b0;
      out_valid_q <= 1'b0;
      last_evt_q  <= '0;
      held_sx_q   <= '1;
      held_sy_q   <= '1;
      held_rx_q   <= '1;
      held_ry_q   <= '1;
    end else begin
      state_q  <= state_d;
      axis_y_q <= axis_y_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Commit the held positions, and the event time when the cooldown has passed
      if (out_load && pen_q) begin
        held_sx_q <= sx_q[8:0];
        held_sy_q <= sy_q;
        held_rx_q <= {1'b0, rx_q};
        held_ry_q <= {1'b0, ry_q};
        if (cool_ok_q) begin
          last_evt_q <= now_q;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      pen_q <= in_pen;
      now_q <= in_now;
      rx_q  <= x_sum[SMP_W+1:2];
      ry_q  <= y_sum[SMP_W+1:2];
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
      den_q  <= den;
    end
    if (state_q == ST_WAIT && div_rsp.done) begin
      if (axis_y_q) begin
        qy_q <= quo_sel;
      end else begin
        qx_q <= quo_sel;
      end
    end
    if (state_q == ST_FIN) begin
      sx_q      <= clamp_axis(tx, XMax);
      sy_q      <= clamp_axis(ty, YMax);
      cool_ok_q <= (now_q - last_evt_q) >= {16'b0, cooldown_q};
    end
    if (out_load) begin
      out_data_q[2:0]   <= (pen_q && cool_ok_q) ? hit_button : BUTTON_NONE;
      out_data_q[3]     <= pen_q;
      out_data_q[12:4]  <= pen_q ? sx_q[8:0] : held_sx_q;
      out_data_q[22:13] <= pen_q ? sy_q : held_sy_q;
      out_data_q[35:23] <= pen_q ? {1'b0, rx_q} : held_rx_q;
      out_data_q[48:36] <= pen_q ? {1'b0, ry_q} : held_ry_q;
      out_data_q[55:49] <= '0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/tcb_checker.sv @@
// ----------------------------------------------------------------------------
// tcb_checker: port-level assertions for the touch calibrate core
// Watches the stream handshakes and the reported button code.
// ----------------------------------------------------------------------------
module tcb_checker import tcb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // Stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Core is busy in the cycle after a poll beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("poll taken while busy");

  // A new result comes only as the core finishes a poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result without finished poll");

  // Button code is legal and needs the pen down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == BUTTON_NONE) ||
                      (m_axis_tdata[3] &&
                       (m_axis_tdata[2:0] == BUTTON_ARM ||
                        m_axis_tdata[2:0] == BUTTON_DEPLOY ||
                        m_axis_tdata[2:0] == BUTTON_YES ||
                        m_axis_tdata[2:0] == BUTTON_NO)))
    else $error("bad button code");

endmodule

bind touch_calibrate_and_button_hit_core tcb_checker u_tcb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
